// ===== hdl/afbt_pkg.sv =====
// Shared types, register indexes and defaults for the affine point and bounds transform.
package afbt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int NUM_LANES     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_E = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_F = 3'd5;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_RECT  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        operation;
        logic signed [COORD_W-1:0]  left_or_x;
        logic signed [COORD_W-1:0]  top_or_y;
        logic signed [COORD_W-1:0]  right_edge;
        logic signed [COORD_W-1:0]  bottom_edge;
        logic                       batch_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
        logic                       saturated;
        logic                       batch_end_out;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  coef_a;
        logic signed [COORD_W-1:0]  coef_b;
        logic signed [COORD_W-1:0]  coef_c;
        logic signed [COORD_W-1:0]  coef_d;
        logic signed [COORD_W-1:0]  offset_e;
        logic signed [COORD_W-1:0]  offset_f;
    } t_coefs;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic                       sat;
    } t_corner;

    // Pipeline advance enables handed to the lanes and the merge stage.
    typedef struct packed {
        logic mul;
        logic sum;
        logic mrg;
    } t_stage_en;

endpackage

// ===== hdl/affine_point_and_bounds_transform.sv =====
// Top level of the affine point and bounds transform: config registers, lanes, pipeline control.
//
// Usage:
//   Six signed fixed-point registers (a, b, c, d, e, f) are written through a plain
//   write port: i_cfg_we, i_cfg_idx and i_cfg_data. Indexes beyond the list are ignored.
//   Write them only while no transfer is in flight. Reset restores the identity map.
//   Input items arrive on i_in_valid / o_in_ready / i_in. Each item either maps a
//   single point or maps the four corners of a rectangle and reports their bounds.
//   Result items leave on o_out_valid / i_out_ready / o_out, one for every input.
//   Four lanes, one per rectangle corner, each run a multiply stage and a
//   shift-add-clamp stage; a merge stage then takes min and max into the output
//   register. Each item is registered in the multiply, shift-add-clamp and merge
//   stages in that order before o_out_valid shows its result, and one item
//   is accepted every clock as long as the receiver keeps taking results.
//   When the receiver stalls, the output register holds its result and the stages
//   behind it keep filling; o_in_ready drops only once all three stages are full.
//   Synchronous active-low reset empties the pipeline and loads the identity
//   coefficients; payload registers are not reset.
module affine_point_and_bounds_transform import afbt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_W-1:0]    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    t_coefs     r_coefs;
    t_stage_en  stage_en;
    logic       r_v1, r_v2, r_v3;
    logic       n_v1, n_v2, n_v3;
    t_op        r_op1, r_op2;
    logic       r_be1, r_be2;
    t_corner    corners [NUM_LANES];
    logic signed [COORD_W-1:0] lane_x [NUM_LANES];
    logic signed [COORD_W-1:0] lane_y [NUM_LANES];

    // Configuration registers. The data word is reinterpreted as signed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_a   <= 32'(1) << FRAC_BITS;
            r_coefs.coef_b   <= '0;
            r_coefs.coef_c   <= '0;
            r_coefs.coef_d   <= 32'(1) << FRAC_BITS;
            r_coefs.offset_e <= '0;
            r_coefs.offset_f <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_A:   r_coefs.coef_a   <= i_cfg_data;
                REG_COEF_B:   r_coefs.coef_b   <= i_cfg_data;
                REG_COEF_C:   r_coefs.coef_c   <= i_cfg_data;
                REG_COEF_D:   r_coefs.coef_d   <= i_cfg_data;
                REG_OFFSET_E: r_coefs.offset_e <= i_cfg_data;
                REG_OFFSET_F: r_coefs.offset_f <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances, so
    // bubbles collapse and the input keeps flowing behind a stalled result.
    always_comb begin
        stage_en.mrg = !r_v3 || i_out_ready;
        stage_en.sum = !r_v2 || stage_en.mrg;
        stage_en.mul = !r_v1 || stage_en.sum;
    end

    assign o_in_ready  = stage_en.mul;
    assign o_out_valid = r_v3;

    always_comb begin
        n_v1 = stage_en.mul ? i_in_valid : r_v1;
        n_v2 = stage_en.sum ? r_v1 : r_v2;
        n_v3 = stage_en.mrg ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // The operation and batch tag ride along with the lane stages.
    always_ff @(posedge i_clk) begin
        if (stage_en.mul) begin
            r_op1 <= i_in.operation;
            r_be1 <= i_in.batch_end_in;
        end
        if (stage_en.sum) begin
            r_op2 <= r_op1;
            r_be2 <= r_be1;
        end
    end

    // Corner order: (left, top), (right, top), (right, bottom), (left, bottom).
    // For a point, lane 0 carries the point itself.
    always_comb begin
        lane_x[0] = i_in.left_or_x;
        lane_y[0] = i_in.top_or_y;
        lane_x[1] = i_in.right_edge;
        lane_y[1] = i_in.top_or_y;
        lane_x[2] = i_in.right_edge;
        lane_y[2] = i_in.bottom_edge;
        lane_x[3] = i_in.left_or_x;
        lane_y[3] = i_in.bottom_edge;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        afbt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (stage_en),
            .i_x      (lane_x[g]),
            .i_y      (lane_y[g]),
            .i_coefs  (r_coefs),
            .o_corner (corners[g])
        );
    end

    afbt_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (stage_en),
        .i_corner    (corners),
        .i_op        (r_op2),
        .i_batch_end (r_be2),
        .o_item      (o_out)
    );

    // A result's bounds are always ordered.
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.min_x <= o_out.max_x) && (o_out.min_y <= o_out.max_y))
        else $error("result bounds out of order");

    // The input is refused only when every stage is full and the output is stalled.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && !i_out_ready))
        else $error("input refused with room in the pipeline");

    // An input transfer always occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted item lost at the multiply stage");

    // A stalled result is not overwritten.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

endmodule

// ===== hdl/afbt_lane.sv =====
// One lane: maps a single point through the affine coefficients in two pipeline stages.
module afbt_lane import afbt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  t_stage_en                  i_en,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  t_coefs                     i_coefs,
    output t_corner                    o_corner
);

    // Shifted products need PROD_W - FRAC_BITS bits; two more cover the three-term sum.
    localparam int SUM_W = PROD_W - FRAC_BITS + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic signed [PROD_W-1:0]  r_p_ax, r_p_cy, r_p_bx, r_p_dy;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    t_corner                   r_corner;
    t_corner                   n_corner;

    // Stage 1: four full-width signed products.
    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p_ax <= PROD_W'(i_coefs.coef_a) * PROD_W'(i_x);
            r_p_cy <= PROD_W'(i_coefs.coef_c) * PROD_W'(i_y);
            r_p_bx <= PROD_W'(i_coefs.coef_b) * PROD_W'(i_x);
            r_p_dy <= PROD_W'(i_coefs.coef_d) * PROD_W'(i_y);
        end
    end

    // Stage 2: floor shift, add the offset, clamp to the 32-bit range.
    always_comb begin
        sum_x = SUM_W'(r_p_ax >>> FRAC_BITS) + SUM_W'(r_p_cy >>> FRAC_BITS)
              + SUM_W'(i_coefs.offset_e);
        sum_y = SUM_W'(r_p_bx >>> FRAC_BITS) + SUM_W'(r_p_dy >>> FRAC_BITS)
              + SUM_W'(i_coefs.offset_f);
        n_corner.sat = 1'b0;
        if (sum_x > SAT_HI) begin
            n_corner.x   = SAT_HI[COORD_W-1:0];
            n_corner.sat = 1'b1;
        end else if (sum_x < SAT_LO) begin
            n_corner.x   = SAT_LO[COORD_W-1:0];
            n_corner.sat = 1'b1;
        end else begin
            n_corner.x   = sum_x[COORD_W-1:0];
        end
        if (sum_y > SAT_HI) begin
            n_corner.y   = SAT_HI[COORD_W-1:0];
            n_corner.sat = 1'b1;
        end else if (sum_y < SAT_LO) begin
            n_corner.y   = SAT_LO[COORD_W-1:0];
            n_corner.sat = 1'b1;
        end else begin
            n_corner.y   = sum_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_corner <= n_corner;
        end
    end

    assign o_corner = r_corner;

endmodule

// ===== hdl/afbt_merge.sv =====
// Merge stage: min and max over the lane results, registered into the result item.
module afbt_merge import afbt_pkg::*; (
    input  logic       i_clk,
    input  t_stage_en  i_en,
    input  t_corner    i_corner [NUM_LANES],
    input  t_op        i_op,
    input  logic       i_batch_end,
    output t_out_item  o_item
);

    t_out_item                  r_item;
    t_out_item                  n_item;
    logic signed [COORD_W-1:0]  lo_x01, lo_x23, hi_x01, hi_x23;
    logic signed [COORD_W-1:0]  lo_y01, lo_y23, hi_y01, hi_y23;

    always_comb begin
        lo_x01 = (i_corner[1].x < i_corner[0].x) ? i_corner[1].x : i_corner[0].x;
        lo_x23 = (i_corner[3].x < i_corner[2].x) ? i_corner[3].x : i_corner[2].x;
        hi_x01 = (i_corner[1].x > i_corner[0].x) ? i_corner[1].x : i_corner[0].x;
        hi_x23 = (i_corner[3].x > i_corner[2].x) ? i_corner[3].x : i_corner[2].x;
        lo_y01 = (i_corner[1].y < i_corner[0].y) ? i_corner[1].y : i_corner[0].y;
        lo_y23 = (i_corner[3].y < i_corner[2].y) ? i_corner[3].y : i_corner[2].y;
        hi_y01 = (i_corner[1].y > i_corner[0].y) ? i_corner[1].y : i_corner[0].y;
        hi_y23 = (i_corner[3].y > i_corner[2].y) ? i_corner[3].y : i_corner[2].y;

        n_item.batch_end_out = i_batch_end;
        unique case (i_op)
            OP_POINT: begin
                // A point uses lane 0 alone.
                n_item.min_x     = i_corner[0].x;
                n_item.max_x     = i_corner[0].x;
                n_item.min_y     = i_corner[0].y;
                n_item.max_y     = i_corner[0].y;
                n_item.saturated = i_corner[0].sat;
            end
            OP_RECT: begin
                n_item.min_x     = (lo_x23 < lo_x01) ? lo_x23 : lo_x01;
                n_item.max_x     = (hi_x23 > hi_x01) ? hi_x23 : hi_x01;
                n_item.min_y     = (lo_y23 < lo_y01) ? lo_y23 : lo_y01;
                n_item.max_y     = (hi_y23 > hi_y01) ? hi_y23 : hi_y01;
                n_item.saturated = i_corner[0].sat | i_corner[1].sat
                                 | i_corner[2].sat | i_corner[3].sat;
            end
            default: begin
                n_item = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mrg) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
